FILE: rtl/core/lki_pkg.sv
// lki_pkg: shared types and constants of the LED keyframe interpolator
// transaction structs, opcodes and the divider request/response structs
// no dependencies
package lki_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned NUM_W  = VAL_W + TIME_W + 1;
  localparam int unsigned DIV_STEPS = VAL_W;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        group;
    logic [2:0]        led_in_group;
    logic              channel;
    logic [3:0]        step_index;
    logic [TIME_W-1:0] step_time;
    logic [VAL_W-1:0]  step_value;
    logic [4:0]        count;
    logic [TIME_W-1:0] progress;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] brightness;
    logic             empty_table;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/core/lki_div.sv
// lki_div: restoring divider, one quotient bit per cycle
// quotient is known to fit in VAL_W bits; depends on lki_pkg
module lki_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lki_pkg::div_req_t req_i,
  output lki_pkg::div_rsp_t rsp_o
);

  localparam int unsigned STEP_W = (lki_pkg::DIV_STEPS > 1) ? $clog2(lki_pkg::DIV_STEPS) : 1;

  logic                       busy_q;
  logic                       done_q;
  logic [STEP_W-1:0]          step_q;
  logic [lki_pkg::TIME_W-1:0] rem_q;
  logic [lki_pkg::TIME_W-1:0] den_q;
  logic [lki_pkg::VAL_W-1:0]  low_q;

  logic [lki_pkg::TIME_W:0]   trial;
  logic [lki_pkg::TIME_W:0]   diff;
  logic                       ge;

  assign trial = {rem_q, low_q[lki_pkg::VAL_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      low_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q
                && (step_q == STEP_W'(lki_pkg::DIV_STEPS - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= req_i.num[lki_pkg::VAL_W +: lki_pkg::TIME_W];
        low_q  <= req_i.num[lki_pkg::VAL_W-1:0];
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q  <= ge ? diff[lki_pkg::TIME_W-1:0] : trial[lki_pkg::TIME_W-1:0];
        low_q  <= {low_q[lki_pkg::VAL_W-2:0], ge};
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(lki_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

endmodule

FILE: rtl/core/led_keyframe_interpolator.sv
// led_keyframe_interpolator: keyframe tables per LED and colour channel
// with piecewise linear lookup; depends on lki_pkg and lki_div
//
// in channel (in_valid_i/in_ready_o/in_i): write keyframe, set keyframe
// count or query transactions. Writes and count updates are stored in the
// accept cycle and produce no result. A query produces one result on the
// out channel (out_valid_o/out_ready_i/out_o).
// A query passes a count read (ST_COUNT) and a scan with one keyframe per
// step (ST_SCAN, k = 1..MAX_KEYFRAMES); an interpolated value then passes
// ST_MUL1, ST_MUL2 and the divider (ST_DIV) until its done flag, and each
// query ends in ST_OUT, which loads the output register. A value before the
// first or past the last keyframe goes from the scan to ST_OUT, an empty
// table from the count read, an out of range table from the accept. One
// transaction is in flight at a time; the next is accepted from the cycle in
// which out_valid_o rises. After reset a sweep clears the keyframe count
// memory, one entry per cycle over all GROUPS*LEDS_PER_GROUP*2 entries (64
// by default), with in_ready_o low. The result sits in an output register:
// a new transaction is accepted while it waits, and a following query
// stalls only at its end until the receiver takes the earlier result.
module led_keyframe_interpolator #(
  parameter int unsigned GROUPS         = 4,
  parameter int unsigned LEDS_PER_GROUP = 8,
  parameter int unsigned MAX_KEYFRAMES  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lki_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lki_pkg::out_t out_o
);

  localparam int unsigned NUM_TABLES = GROUPS * LEDS_PER_GROUP * 2;
  localparam int unsigned NUM_SLOTS  = NUM_TABLES * MAX_KEYFRAMES;
  localparam int unsigned TAB_W      = $clog2(NUM_TABLES);
  localparam int unsigned ADDR_W     = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W      = $clog2(MAX_KEYFRAMES + 1);
  localparam int unsigned KF_W       = lki_pkg::TIME_W + lki_pkg::VAL_W;
  localparam int unsigned TW         = lki_pkg::TIME_W;
  localparam int unsigned VW         = lki_pkg::VAL_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_COUNT, ST_SCAN, ST_MUL1, ST_MUL2, ST_DIV, ST_OUT
  } state_e;

  state_e                     state_q;
  logic [TAB_W-1:0]           clr_q;
  logic [ADDR_W-1:0]          base_q;
  logic [TW-1:0]              p_q;
  logic [CNT_W-1:0]           n_q;
  logic [CNT_W-1:0]           i_q;
  logic [TW-1:0]              t1_q, t2_q;
  logic [VW-1:0]              v1_q, v2_q;
  logic [TW+VW-1:0]           prod_q;
  lki_pkg::out_t              res_q;
  lki_pkg::out_t              out_q;
  logic                       out_valid_q;

  logic [KF_W-1:0]            kf_mem [NUM_SLOTS];
  logic [KF_W-1:0]            kf_rdata_q;
  logic [CNT_W-1:0]           cnt_mem [NUM_TABLES];
  logic [CNT_W-1:0]           cnt_rdata_q;

  logic                       accept;
  logic                       tab_ok;
  logic [TAB_W-1:0]           tab_idx;
  logic [ADDR_W-1:0]          tab_base;
  logic                       kf_we;
  logic [ADDR_W-1:0]          kf_waddr;
  logic                       kf_re;
  logic [ADDR_W-1:0]          kf_raddr;
  logic                       cnt_we;
  logic [TAB_W-1:0]           cnt_waddr;
  logic [CNT_W-1:0]           cnt_wdata;
  logic [CNT_W-1:0]           i_next;
  logic [TW-1:0]              cur_t;
  logic [VW-1:0]              cur_v;
  logic [VW-1:0]              mul_a;
  logic [TW-1:0]              mul_b;
  logic [TW+VW-1:0]           mul_p;
  logic                       out_free;
  lki_pkg::div_req_t          div_req;
  lki_pkg::div_rsp_t          div_rsp;

  assign accept   = in_valid_i && in_ready_o;
  assign tab_ok   = (int'(in_i.group) < GROUPS) && (int'(in_i.led_in_group) < LEDS_PER_GROUP);
  assign tab_idx  = TAB_W'((int'(in_i.group) * LEDS_PER_GROUP + int'(in_i.led_in_group)) * 2
                           + int'(in_i.channel));
  assign tab_base = ADDR_W'(int'(tab_idx) * MAX_KEYFRAMES);
  assign kf_we    = accept && (in_i.opcode == lki_pkg::OP_WRITE) && tab_ok
                    && (int'(in_i.step_index) < MAX_KEYFRAMES);
  assign kf_waddr = tab_base + ADDR_W'(in_i.step_index);

  assign i_next   = i_q + CNT_W'(1);
  assign kf_re    = (state_q == ST_COUNT) || (state_q == ST_SCAN);
  assign kf_raddr = (state_q == ST_COUNT) ? base_q : base_q + ADDR_W'(i_next);
  assign cur_t    = kf_rdata_q[VW +: TW];
  assign cur_v    = kf_rdata_q[VW-1:0];

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = tab_idx;
    cnt_wdata = (int'(in_i.count) > MAX_KEYFRAMES) ? CNT_W'(MAX_KEYFRAMES)
                                                    : CNT_W'(in_i.count);
    if (state_q == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else if (accept && (in_i.opcode == lki_pkg::OP_COUNT) && tab_ok) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (kf_we) begin
      kf_mem[kf_waddr] <= {in_i.step_time, in_i.step_value};
    end
    if (kf_re) begin
      kf_rdata_q <= kf_mem[kf_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rdata_q <= cnt_mem[tab_idx];
    end
  end

  assign mul_a = (state_q == ST_MUL1) ? v1_q : v2_q;
  assign mul_b = (state_q == ST_MUL1) ? (t2_q - p_q) : (p_q - t1_q);
  assign mul_p = mul_a * mul_b;

  assign div_req.start = (state_q == ST_MUL2);
  assign div_req.num   = lki_pkg::NUM_W'(prod_q) + lki_pkg::NUM_W'(mul_p);
  assign div_req.den   = t2_q - t1_q;

  lki_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      p_q         <= '0;
      n_q         <= '0;
      i_q         <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      v1_q        <= '0;
      v2_q        <= '0;
      prod_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + TAB_W'(1);
          if (clr_q == TAB_W'(NUM_TABLES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (in_i.opcode == lki_pkg::OP_QUERY)) begin
            base_q <= tab_base;
            p_q    <= in_i.progress;
            if (tab_ok) begin
              state_q <= ST_COUNT;
            end else begin
              res_q   <= '{brightness: '0, empty_table: 1'b1};
              state_q <= ST_OUT;
            end
          end
        end
        ST_COUNT: begin
          n_q <= cnt_rdata_q;
          i_q <= '0;
          if (cnt_rdata_q == '0) begin
            res_q   <= '{brightness: '0, empty_table: 1'b1};
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cur_t <= p_q) begin
            t1_q <= cur_t;
            v1_q <= cur_v;
            i_q  <= i_next;
            if (i_next == n_q) begin
              res_q   <= '{brightness: cur_v, empty_table: 1'b0};
              state_q <= ST_OUT;
            end
          end else if (i_q == '0) begin
            res_q   <= '{brightness: cur_v, empty_table: 1'b0};
            state_q <= ST_OUT;
          end else begin
            t2_q    <= cur_t;
            v2_q    <= cur_v;
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_q  <= mul_p;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res_q   <= '{brightness: div_rsp.quot, empty_table: 1'b0};
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q < n_q))
    else $error("keyframe scan index past the table count");

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result register loaded outside the result phase");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.empty_table) |-> (out_o.brightness == '0))
    else $error("empty table transaction with nonzero brightness");

endmodule
